@@ rtl/rasi_pkg.sv @@
// Shared types and constants for the route adjacent-swap improver.
// Holds command codes, microcode step and condition encodings, and the
// control/status structs exchanged between the sequencer and the datapath.
package rasi_pkg;

    // Input command codes
    localparam logic [1:0] CMD_WR_DIST  = 2'd0;
    localparam logic [1:0] CMD_WR_ROUTE = 2'd1;
    localparam logic [1:0] CMD_RUN      = 2'd2;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int NODE_W  = 6;
    localparam int SLOT_W  = 5;
    localparam int RLEN_W  = 6;
    localparam int EDGE_W  = 20;
    localparam int DIST_W  = 25;

    // Widths wide enough to range-check fields against any parameter value
    localparam int NODE_EXT_W = 11;
    localparam int POS_EXT_W  = 9;

    // Microcode step addresses
    typedef enum logic [3:0] {
        S_IDLE      = 4'd0,
        S_CHECK     = 4'd1,
        S_SCAN_INIT = 4'd2,
        S_SCAN      = 4'd3,
        S_DRAIN_A   = 4'd4,
        S_DRAIN_B   = 4'd5,
        S_DECIDE    = 4'd6,
        S_SWAP_A    = 4'd7,
        S_SWAP_B    = 4'd8,
        S_NEXT      = 4'd9,
        S_EMIT_INIT = 4'd10,
        S_EMIT_RD   = 4'd11,
        S_EMIT_LOAD = 4'd12,
        S_EMIT_WAIT = 4'd13,
        S_EMIT_NEXT = 4'd14,
        S_DONE      = 4'd15
    } step_t;

    // Jump conditions: the jump is taken when the condition holds
    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_ALWAYS    = 3'd1,
        C_NO_RUN    = 3'd2,
        C_NO_SWAP   = 3'd3,
        C_SCAN_MORE = 3'd4,
        C_NOT_LESS  = 3'd5,
        C_OUT_BUSY  = 3'd6,
        C_NOT_LAST  = 3'd7
    } cond_t;

    // Datapath micro-operations of one control word
    typedef struct packed {
        logic take_in;   // input channel is ready this step
        logic scan_clr;  // clear position counter and accumulator
        logic rd_issue;  // issue route read at current position
        logic pos_inc;   // advance position counter
        logic map_swap;  // read with positions i and i+1 exchanged, feed the edge pipe
        logic decide;    // keep candidate if below running best
        logic wr_a;      // write back swapped node at i
        logic wr_b;      // write back swapped node at i+1
        logic i_inc;     // advance swap position
        logic out_load;  // load the result register
    } dp_ctl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic no_run;
        logic no_swap;
        logic scan_more;
        logic not_less;
        logic out_busy;
        logic not_last;
    } dp_stat_t;

endpackage

@@ rtl/rasi_sequencer.sv @@
// Microcode sequencer: step counter, control-word ROM and jump logic.
// Depends on rasi_pkg for step, condition and control-word types.
module rasi_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  rasi_pkg::dp_stat_t  stat,
    output rasi_pkg::dp_ctl_t   ctl
);
    import rasi_pkg::*;

    typedef struct packed {
        dp_ctl_t op;
        cond_t   cond;
        step_t   target;
    } uword_t;

    step_t  upc_reg;
    step_t  upc_next;
    uword_t uw;
    logic   jump;

    // Control store
    function automatic uword_t rom_word(input step_t s);
        uword_t w;
        w = '0;
        unique case (s)
            S_IDLE:      begin w.op.take_in = 1'b1; w.cond = C_NO_RUN; w.target = S_IDLE; end
            S_CHECK:     begin w.cond = C_NO_SWAP; w.target = S_EMIT_INIT; end
            S_SCAN_INIT: begin w.op.scan_clr = 1'b1; end
            S_SCAN:
            begin
                w.op.rd_issue = 1'b1;
                w.op.pos_inc  = 1'b1;
                w.op.map_swap = 1'b1;
                w.cond        = C_SCAN_MORE;
                w.target      = S_SCAN;
            end
            S_DRAIN_A:   begin end
            S_DRAIN_B:   begin end
            S_DECIDE:    begin w.op.decide = 1'b1; w.cond = C_NOT_LESS; w.target = S_NEXT; end
            S_SWAP_A:    begin w.op.wr_a = 1'b1; end
            S_SWAP_B:    begin w.op.wr_b = 1'b1; end
            S_NEXT:      begin w.op.i_inc = 1'b1; w.cond = C_ALWAYS; w.target = S_CHECK; end
            S_EMIT_INIT: begin w.op.scan_clr = 1'b1; end
            S_EMIT_RD:   begin w.op.rd_issue = 1'b1; end
            S_EMIT_LOAD: begin w.op.out_load = 1'b1; end
            S_EMIT_WAIT: begin w.cond = C_OUT_BUSY; w.target = S_EMIT_WAIT; end
            S_EMIT_NEXT:
            begin
                w.op.pos_inc = 1'b1;
                w.cond       = C_NOT_LAST;
                w.target     = S_EMIT_RD;
            end
            S_DONE:      begin w.cond = C_ALWAYS; w.target = S_IDLE; end
            default:     begin end
        endcase
        return w;
    endfunction

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= S_IDLE;
        else
            upc_reg <= upc_next;
    end

    // Condition select and next step
    always_comb
    begin
        uw = rom_word(upc_reg);
        unique case (uw.cond)
            C_NEVER:     jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_NO_RUN:    jump = stat.no_run;
            C_NO_SWAP:   jump = stat.no_swap;
            C_SCAN_MORE: jump = stat.scan_more;
            C_NOT_LESS:  jump = stat.not_less;
            C_OUT_BUSY:  jump = stat.out_busy;
            C_NOT_LAST:  jump = stat.not_last;
            default:     jump = 1'b0;
        endcase
        upc_next = jump ? uw.target : step_t'(4'(upc_reg) + 4'd1);
        ctl      = uw.op;
    end

endmodule

@@ rtl/rasi_datapath.sv @@
// Datapath: distance and route memories, edge-sum pipeline, running best
// and result register. Driven by rasi_sequencer control words; uses rasi_pkg.
module rasi_datapath #(
    parameter int NODE_COUNT = 64,
    parameter int ROUTE_MAX  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rasi_pkg::dp_ctl_t                   ctl,
    output rasi_pkg::dp_stat_t                  stat,
    input  logic                                in_valid,
    input  logic [rasi_pkg::CMD_W-1:0]          command,
    input  logic [rasi_pkg::NODE_W-1:0]         from_node,
    input  logic [rasi_pkg::NODE_W-1:0]         to_node,
    input  logic [rasi_pkg::EDGE_W-1:0]         edge_length,
    input  logic [rasi_pkg::SLOT_W-1:0]         slot,
    input  logic [rasi_pkg::NODE_W-1:0]         slot_node,
    input  logic [rasi_pkg::RLEN_W-1:0]         route_length,
    input  logic [rasi_pkg::DIST_W-1:0]         start_length,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rasi_pkg::SLOT_W-1:0]         out_slot,
    output logic [rasi_pkg::NODE_W-1:0]         out_node,
    output logic [rasi_pkg::DIST_W-1:0]         best_length,
    output logic                                improved,
    output logic                                last
);
    import rasi_pkg::*;

    localparam int NW      = $clog2(NODE_COUNT);
    localparam int PW      = $clog2(ROUTE_MAX);
    localparam int LW      = $clog2(ROUTE_MAX + 1);
    localparam int D_DEPTH = 1 << (2 * NW);

    // Storage
    logic [EDGE_W-1:0] dist_mem  [D_DEPTH];
    logic [NODE_W-1:0] route_mem [ROUTE_MAX];

    // Control registers
    logic              v1_reg, v2_reg;
    logic              out_valid_reg;
    logic [DIST_W-1:0] best_reg;
    logic              improved_reg;

    // Payload registers
    logic [LW-1:0]     len_reg, pos_reg, i_reg, tag1_reg;
    logic [DIST_W-1:0] acc_reg;
    logic [NODE_W-1:0] route_q, prev_reg, ni_reg, ni1_reg;
    logic              prev_oor_reg, oor2_reg;
    logic [EDGE_W-1:0] dist_q;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [NODE_W-1:0] out_node_reg;
    logic              out_last_reg;

    // Combinational helpers
    logic                  in_fire, run_go;
    logic [NODE_EXT_W-1:0] from_ext, to_ext, node_ext, prev_ext;
    logic [POS_EXT_W-1:0]  slot_ext, rlen_ext, len_sat;
    logic [LW-1:0]         i1, len_m1, raddr_full;
    logic [PW-1:0]         route_waddr;
    logic [NODE_W-1:0]     route_wdata;
    logic                  route_we;
    logic                  node_oor;
    logic [DIST_W:0]       acc_sum;
    logic [EDGE_W-1:0]     edge_add;

    always_comb
    begin
        in_fire  = in_valid && ctl.take_in;
        run_go   = in_fire && (command == CMD_RUN);
        from_ext = NODE_EXT_W'(from_node);
        to_ext   = NODE_EXT_W'(to_node);
        node_ext = NODE_EXT_W'(route_q);
        prev_ext = NODE_EXT_W'(prev_reg);
        slot_ext = POS_EXT_W'(slot);
        rlen_ext = POS_EXT_W'(route_length);
        node_oor = (node_ext >= NODE_EXT_W'(NODE_COUNT));
        i1       = i_reg + 1'b1;
        len_m1   = len_reg - 1'b1;

        // Clamp run length into 2..ROUTE_MAX
        if (rlen_ext < POS_EXT_W'(2))
            len_sat = POS_EXT_W'(2);
        else if (rlen_ext > POS_EXT_W'(ROUTE_MAX))
            len_sat = POS_EXT_W'(ROUTE_MAX);
        else
            len_sat = rlen_ext;

        // Read address, with i and i+1 exchanged during a trial scan
        if (ctl.map_swap && pos_reg == i_reg)
            raddr_full = i1;
        else if (ctl.map_swap && pos_reg == i1)
            raddr_full = i_reg;
        else
            raddr_full = pos_reg;

        // Route write port: load from input or swap write-back
        route_we    = 1'b0;
        route_waddr = slot_ext[PW-1:0];
        route_wdata = slot_node;
        if (ctl.wr_a)
        begin
            route_we    = 1'b1;
            route_waddr = i_reg[PW-1:0];
            route_wdata = ni_reg;
        end
        else if (ctl.wr_b)
        begin
            route_we    = 1'b1;
            route_waddr = i1[PW-1:0];
            route_wdata = ni1_reg;
        end
        else if (in_fire && command == CMD_WR_ROUTE && slot_ext < POS_EXT_W'(ROUTE_MAX))
        begin
            route_we = 1'b1;
        end

        // Saturating accumulate; out-of-range nodes contribute zero
        edge_add = oor2_reg ? '0 : dist_q;
        acc_sum  = {1'b0, acc_reg} + (DIST_W + 1)'(edge_add);
    end

    // Distance memory
    always_ff @(posedge clk)
    begin
        if (in_fire && command == CMD_WR_DIST
            && from_ext < NODE_EXT_W'(NODE_COUNT) && to_ext < NODE_EXT_W'(NODE_COUNT))
            dist_mem[{from_ext[NW-1:0], to_ext[NW-1:0]}] <= edge_length;
        if (v1_reg)
            dist_q <= dist_mem[{prev_ext[NW-1:0], node_ext[NW-1:0]}];
    end

    // Route memory
    always_ff @(posedge clk)
    begin
        if (route_we)
            route_mem[route_waddr] <= route_wdata;
        if (ctl.rd_issue)
            route_q <= route_mem[raddr_full[PW-1:0]];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            best_reg      <= '0;
            improved_reg  <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.rd_issue && ctl.map_swap;
            v2_reg <= v1_reg && (tag1_reg != '0);
            if (run_go)
            begin
                best_reg     <= start_length;
                improved_reg <= 1'b0;
            end
            else if (ctl.decide && acc_reg < best_reg)
            begin
                best_reg     <= acc_reg;
                improved_reg <= 1'b1;
            end
            if (ctl.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload and counters
    always_ff @(posedge clk)
    begin
        if (run_go)
        begin
            len_reg <= LW'(len_sat);
            i_reg   <= LW'(1);
        end
        else if (ctl.i_inc)
            i_reg <= i1;

        if (ctl.scan_clr)
            pos_reg <= '0;
        else if (ctl.pos_inc)
            pos_reg <= pos_reg + 1'b1;

        if (ctl.rd_issue && ctl.map_swap)
            tag1_reg <= pos_reg;

        // Edge stage: remember previous node and the swapped pair
        if (v1_reg)
        begin
            prev_reg     <= route_q;
            prev_oor_reg <= node_oor;
            oor2_reg     <= node_oor || prev_oor_reg;
            if (tag1_reg == i_reg)
                ni_reg <= route_q;
            if (tag1_reg == i1)
                ni1_reg <= route_q;
        end

        // Sum stage
        if (ctl.scan_clr)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_sum[DIST_W] ? {DIST_W{1'b1}} : acc_sum[DIST_W-1:0];

        if (ctl.out_load)
        begin
            out_slot_reg <= SLOT_W'(pos_reg);
            out_node_reg <= route_q;
            out_last_reg <= (pos_reg == len_m1);
        end
    end

    // Status to sequencer
    always_comb
    begin
        stat.no_run    = !run_go;
        stat.no_swap   = ((LW + 1)'(i_reg) + (LW + 1)'(2)) >= (LW + 1)'(len_reg);
        stat.scan_more = (pos_reg != len_m1);
        stat.not_less  = !(acc_reg < best_reg);
        stat.out_busy  = out_valid_reg;
        stat.not_last  = !out_last_reg;
    end

    assign out_valid   = out_valid_reg;
    assign out_slot    = out_slot_reg;
    assign out_node    = out_node_reg;
    assign best_length = best_reg;
    assign improved    = improved_reg;
    assign last        = out_last_reg;

`ifndef SYNTHESIS
    // No edge read is in flight while a result is pending
    a_pipe_vs_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg || v2_reg) |-> !out_valid_reg)
        else $error("edge pipeline active while result pending");

    // An accepted trial becomes the running best
    a_keep_best: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.decide && acc_reg < best_reg) |=> (improved_reg && best_reg == $past(acc_reg)))
        else $error("accepted trial not recorded as best");

    // Input is only taken with the edge pipeline drained
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take_in |-> (!v1_reg && !v2_reg && !out_valid_reg))
        else $error("input taken while work in flight");
`endif

endmodule

@@ rtl/route_adjacent_swap_improver.sv @@
// Route adjacent-swap improver.
// Channels: input items (valid/ready) carry a command: write distance entry,
// write route node, or run. Result items (valid/ready) carry one route position
// each. A write command is one transfer and produces no result.
// A run sweeps swap positions 1 to length-3; each trial re-sums the whole route
// at one edge per cycle through the route memory, distance memory and adder pipe,
// and when a swap is kept both swapped nodes are written back to the route.
// After the sweep the route is emitted one result at a time; the next result is
// loaded only after the previous one has transferred.
// The sequencer waits on a stalled receiver: a stalled result simply holds in the
// output register, and no new input is taken until the last result transfers.
// Reset clears the sequencer, pipe valids, running best and result valid; the
// distance and route memories are not cleared and must be loaded before a run.
// Depends on rasi_pkg, rasi_sequencer and rasi_datapath.
module route_adjacent_swap_improver #(
    parameter int NODE_COUNT = 64,
    parameter int ROUTE_MAX  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rasi_pkg::CMD_W-1:0]          command,
    input  logic [rasi_pkg::NODE_W-1:0]         from_node,
    input  logic [rasi_pkg::NODE_W-1:0]         to_node,
    input  logic [rasi_pkg::EDGE_W-1:0]         edge_length,
    input  logic [rasi_pkg::SLOT_W-1:0]         slot,
    input  logic [rasi_pkg::NODE_W-1:0]         slot_node,
    input  logic [rasi_pkg::RLEN_W-1:0]         route_length,
    input  logic [rasi_pkg::DIST_W-1:0]         start_length,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rasi_pkg::SLOT_W-1:0]         out_slot,
    output logic [rasi_pkg::NODE_W-1:0]         out_node,
    output logic [rasi_pkg::DIST_W-1:0]         best_length,
    output logic                                improved,
    output logic                                last
);
    import rasi_pkg::*;

    dp_ctl_t  ctl;
    dp_stat_t stat;

    // Control store and step counter
    rasi_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // Memories and arithmetic
    rasi_datapath #(
        .NODE_COUNT (NODE_COUNT),
        .ROUTE_MAX  (ROUTE_MAX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .in_valid     (in_valid),
        .command      (command),
        .from_node    (from_node),
        .to_node      (to_node),
        .edge_length  (edge_length),
        .slot         (slot),
        .slot_node    (slot_node),
        .route_length (route_length),
        .start_length (start_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_slot     (out_slot),
        .out_node     (out_node),
        .best_length  (best_length),
        .improved     (improved),
        .last         (last)
    );

    assign in_ready = ctl.take_in;

endmodule
